// ----- rtl/key_sequence_trie_matcher_core_defines.svh -----
// ----------------------------------------------------------------------------
// Key sequence trie matcher - assertion macros
// Shared concurrent assertion forms, clocked on aclk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef KEY_SEQUENCE_TRIE_MATCHER_CORE_DEFINES_SVH
`define KEY_SEQUENCE_TRIE_MATCHER_CORE_DEFINES_SVH

// Antecedent holds -> consequent holds in the same cycle
`define KSM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("%m: label failed");

// Antecedent holds -> consequent holds in the next cycle
`define KSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("%m: label failed");

`endif

// ----- rtl/ksm_pkg.sv -----
// ----------------------------------------------------------------------------
// Key sequence trie matcher - package
// Sizes, field layouts, entry encoding and status codes shared by the matcher modules, checker and testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package ksm_pkg;

    // Trie geometry
    localparam int NODE_COUNT     = 64;
    localparam int ALPHABET_SIZE  = 256;
    localparam int MAX_KEY_LENGTH = 20;
    localparam int SYMBOL_COUNT   = 1024;

    // Fixed field widths
    localparam int CHAR_FIELD_W = 8;
    localparam int SYM_W        = 10;
    localparam int STATUS_W     = 3;
    localparam int LEN_W        = 5;

    // Derived widths
    localparam int NODE_W      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int ALLOC_W     = $clog2(NODE_COUNT + 1);
    localparam int CHAR_W      = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int ADDR_W      = NODE_W + CHAR_W;
    localparam int TABLE_DEPTH = NODE_COUNT * (2 ** CHAR_W);
    localparam int PAYLOAD_W   = (NODE_W > SYM_W) ? NODE_W : SYM_W;
    localparam int TAG_W       = 2;
    localparam int ENTRY_W     = TAG_W + PAYLOAD_W;
    localparam int MLEN_W      = $clog2(MAX_KEY_LENGTH + 1);

    // Table entry tag
    typedef enum logic [TAG_W-1:0] {
        TAG_EMPTY = 2'd0,
        TAG_CHILD = 2'd1,
        TAG_SYM   = 2'd2
    } tag_t;

    // Request kind
    typedef enum logic {
        CMD_DEFINE = 1'b0,
        CMD_MATCH  = 1'b1
    } cmd_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DEFINED  = 3'd0,
        ST_NO_NODES = 3'd1,
        ST_PENDING  = 3'd2,
        ST_MISS     = 3'd3,
        ST_MATCHED  = 3'd4,
        ST_TOO_LONG = 3'd5
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_EVAL  = 2'd2
    } ctrl_state_t;

    // Input request
    typedef struct packed {
        cmd_t                    cmd;
        logic [CHAR_FIELD_W-1:0] key_char;
        logic                    last_char;
        logic [SYM_W-1:0]        symbol_id;
    } in_item_t;

    // Result
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SYM_W-1:0]    matched_symbol;
        logic [LEN_W-1:0]    sequence_length;
    } out_item_t;

    // Controller -> datapath
    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic commit;
    } ctrl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic out_full;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/key_sequence_trie_matcher_core.sv -----
// ----------------------------------------------------------------------------
// Key sequence trie matcher core - top level
// Defines key sequences into a trie of character tables and matches typed keys.
// ----------------------------------------------------------------------------
// For each request the accept cycle launches the read of the node memory at
// {cursor, character}; once the read data is registered, the controller
// evaluates the returned entry, performs the optional write and loads the
// result register. Evaluation holds while an earlier result is still waiting
// on m_ready, but a new request is accepted while a result waits. After reset
// the node memory is cleared one entry per cycle, all NODE_COUNT *
// ALPHABET_SIZE entries, with s_ready low for that time. Every request returns
// exactly one result.
`default_nettype none

module key_sequence_trie_matcher_core import ksm_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    ksm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ksm_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ----- rtl/ksm_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ksm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/ksm_datapath.sv -----
// ----------------------------------------------------------------------------
// Key sequence trie matcher - datapath
// Node memory, cursors, node allocator, entry evaluation and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ksm_datapath import ksm_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire ctrl_cmd_t  cmd,
    output dp_status_t      status,
    input  wire in_item_t   s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_item_t       m_data
);

    // Walk and allocation state
    logic [NODE_W-1:0]  dcur_reg, dcur_next;
    logic [NODE_W-1:0]  mcur_reg, mcur_next;
    logic [MLEN_W-1:0]  mlen_reg, mlen_next;
    logic [ALLOC_W-1:0] alloc_reg, alloc_next;
    logic               aband_reg, aband_next;
    logic [ADDR_W-1:0]  clr_cnt_reg;
    in_item_t           item_reg;
    logic               m_valid_reg;
    out_item_t          m_data_reg;

    // Memory ports
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] rd_data;
    in_item_t           rd_item;

    // Evaluation
    logic               eval_we;
    logic [ENTRY_W-1:0] eval_wdata;
    out_item_t          res;
    logic [TAG_W-1:0]   rd_tag;
    logic               ch_bad;
    logic [PAYLOAD_W-1:0] sym_sat;
    logic [MLEN_W-1:0]  len_inc;

    ksm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_node_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (rd_data)
    );

    // Read address: the arriving request at accept, the held one while it waits
    always_comb begin
        rd_item   = cmd.accept ? s_data : item_reg;
        ram_raddr = (rd_item.cmd == CMD_MATCH)
                  ? {mcur_reg, rd_item.key_char[CHAR_W-1:0]}
                  : {dcur_reg, rd_item.key_char[CHAR_W-1:0]};
    end

    // Write port: clearing pass has priority over define writes
    always_comb begin
        if (cmd.clear_wr) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = eval_we && cmd.commit;
            ram_waddr = {dcur_reg, item_reg.key_char[CHAR_W-1:0]};
            ram_wdata = eval_wdata;
        end
    end

    // Entry evaluation for the held request
    always_comb begin
        dcur_next  = dcur_reg;
        mcur_next  = mcur_reg;
        mlen_next  = mlen_reg;
        alloc_next = alloc_reg;
        aband_next = aband_reg;
        eval_we    = 1'b0;
        eval_wdata = '0;
        res        = '0;
        rd_tag     = rd_data[ENTRY_W-1 -: TAG_W];
        ch_bad     = 32'(item_reg.key_char) >= ALPHABET_SIZE;
        sym_sat    = (32'(item_reg.symbol_id) >= SYMBOL_COUNT)
                   ? PAYLOAD_W'(SYMBOL_COUNT - 1) : PAYLOAD_W'(item_reg.symbol_id);
        len_inc    = mlen_reg + MLEN_W'(1);

        if (item_reg.cmd == CMD_DEFINE) begin
            if (aband_reg || ch_bad) begin
                // abandoned key: swallow until the last character
                res.status = ST_NO_NODES;
                if (item_reg.last_char) begin
                    aband_next = 1'b0;
                    dcur_next  = '0;
                end else begin
                    aband_next = 1'b1;
                end
            end else if (item_reg.last_char) begin
                // bind symbol, drops any subtree under this entry
                eval_we    = 1'b1;
                eval_wdata = {TAG_SYM, sym_sat};
                dcur_next  = '0;
                res.status = ST_DEFINED;
            end else if (rd_tag == TAG_CHILD) begin
                dcur_next  = rd_data[NODE_W-1:0];
                res.status = ST_PENDING;
            end else if (alloc_reg >= ALLOC_W'(NODE_COUNT)) begin
                aband_next = 1'b1;
                res.status = ST_NO_NODES;
            end else begin
                // link a fresh node
                eval_we    = 1'b1;
                eval_wdata = {TAG_CHILD, PAYLOAD_W'(alloc_reg)};
                dcur_next  = NODE_W'(alloc_reg);
                alloc_next = alloc_reg + ALLOC_W'(1);
                res.status = ST_PENDING;
            end
        end else begin
            if (mlen_reg >= MLEN_W'(MAX_KEY_LENGTH)) begin
                mcur_next  = '0;
                mlen_next  = '0;
                res.status = ST_TOO_LONG;
            end else if (!ch_bad && rd_tag == TAG_CHILD) begin
                mcur_next  = rd_data[NODE_W-1:0];
                mlen_next  = len_inc;
                res.status = ST_PENDING;
            end else if (!ch_bad && rd_tag == TAG_SYM) begin
                mcur_next              = '0;
                mlen_next              = '0;
                res.status             = ST_MATCHED;
                res.matched_symbol     = rd_data[SYM_W-1:0];
                res.sequence_length    = LEN_W'(len_inc);
            end else begin
                mcur_next  = '0;
                mlen_next  = '0;
                res.status = ST_MISS;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcur_reg    <= '0;
            mcur_reg    <= '0;
            mlen_reg    <= '0;
            alloc_reg   <= ALLOC_W'(1);
            aband_reg   <= 1'b0;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear_wr) begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (cmd.commit) begin
                dcur_reg    <= dcur_next;
                mcur_reg    <= mcur_next;
                mlen_reg    <= mlen_next;
                alloc_reg   <= alloc_next;
                aband_reg   <= aband_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_reg <= s_data;
        end
        if (cmd.commit) begin
            m_data_reg <= res;
        end
    end

    assign status.clear_last = (clr_cnt_reg == ADDR_W'(TABLE_DEPTH - 1));
    assign status.out_full   = m_valid_reg && !m_ready;
    assign m_valid           = m_valid_reg;
    assign m_data            = m_data_reg;

endmodule

`default_nettype wire

// ----- rtl/ksm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Key sequence trie matcher - controller
// Sequences the clearing pass, request accept and the evaluate/commit step.
// ----------------------------------------------------------------------------
`default_nettype none

module ksm_ctrl import ksm_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire dp_status_t  status,
    output ctrl_cmd_t        cmd
);

    ctrl_state_t state_reg, state_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (status.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!status.out_full) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Outputs
    always_comb begin
        s_ready      = 1'b0;
        cmd.clear_wr = 1'b0;
        cmd.accept   = 1'b0;
        cmd.commit   = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear_wr = 1'b1;
            end
            S_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            S_EVAL: begin
                // result register must be free or draining this cycle
                cmd.commit = !status.out_full;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ksm_checker.sv -----
// ----------------------------------------------------------------------------
// Key sequence trie matcher - port checker
// Watches the top-level ports for result and handshake consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "key_sequence_trie_matcher_core_defines.svh"

module ksm_checker import ksm_pkg::*; (
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    // stalled result holds
    `KSM_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // one request in evaluation at a time
    `KSM_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready)

    // only defined status codes
    `KSM_ASSERT_SAME(a_status_range, m_valid, m_data.status <= ST_TOO_LONG)

    // symbol and length only on a match
    `KSM_ASSERT_SAME(a_clean_nonmatch, m_valid && m_data.status != ST_MATCHED, m_data.matched_symbol == '0 && m_data.sequence_length == '0)

    // matched length within the key limit
    `KSM_ASSERT_SAME(a_match_len, m_valid && m_data.status == ST_MATCHED, m_data.sequence_length != '0 && 32'(m_data.sequence_length) <= MAX_KEY_LENGTH)

endmodule

bind key_sequence_trie_matcher_core ksm_checker u_ksm_checker (.*);

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Key sequence trie matcher - testbench
// Drives define and match requests through the valid/ready input channel,
// predicts each result with a behavioral trie kept inside the testbench, and
// compares every result field by field. Short directed tests come first, then
// a long random run of well-formed key definitions and key walks mixed with
// noise. Both channels idle at random.
// ----------------------------------------------------------------------------

module tb_top;
    import ksm_pkg::*;

    localparam int WATCHDOG_LIMIT = 70000;  // covers the table clear after reset
    localparam int RANDOM_ITEMS   = 1850;
    localparam int KEY_SLOTS      = 32;
    localparam int KEY_MAX        = 24;
    localparam int REPORT_LIMIT   = 10;

    // DUT interface
    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    key_sequence_trie_matcher_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predicted trie and walk state
    tag_t                 trie_tag     [NODE_COUNT][ALPHABET_SIZE];
    logic [PAYLOAD_W-1:0] trie_payload [NODE_COUNT][ALPHABET_SIZE];
    int unsigned          nodes_used;
    int unsigned          def_node;
    bit                   def_dropped;
    int unsigned          walk_node;
    int unsigned          walk_len;

    out_item_t expected_results[$];
    out_item_t oldest_expected;

    // Keys defined so far, reused for key walks
    logic [7:0]  stored_key [KEY_SLOTS][KEY_MAX];
    int unsigned stored_len [KEY_SLOTS];
    int unsigned stored_count;
    logic [7:0]  key_buf    [KEY_MAX];
    int unsigned key_buf_len;
    logic [7:0]  char_pool  [8] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h61, 8'h62, 8'h63, 8'h7A};

    // Idling controls and bookkeeping
    bit          sender_gaps_on   = 1'b1;
    bit          receiver_gaps_on = 1'b1;
    int unsigned defines_sent;
    int unsigned matches_sent;
    int unsigned results_checked;
    int unsigned fail_count;
    int unsigned status_seen [6];
    int unsigned quiet_cycles;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    task automatic clear_trie_model();
        foreach (trie_tag[n, c]) begin
            trie_tag[n][c]     = TAG_EMPTY;
            trie_payload[n][c] = '0;
        end
        nodes_used  = 1;
        def_node    = 0;
        def_dropped = 1'b0;
        walk_node   = 0;
        walk_len    = 0;
    endtask

    function automatic out_item_t predict_key_result(in_item_t req);
        out_item_t   res;
        int unsigned row;
        int unsigned ch;
        tag_t        entry_tag;
        res = '0;
        ch  = int'(req.key_char);
        if (req.cmd == CMD_DEFINE) begin
            if (def_dropped || ch >= ALPHABET_SIZE) begin
                // abandoned key: the last character closes it
                if (req.last_char) begin
                    def_dropped = 1'b0;
                    def_node    = 0;
                end else begin
                    def_dropped = 1'b1;
                end
                res.status = ST_NO_NODES;
            end else begin
                row = (def_node < NODE_COUNT) ? def_node : 0;
                if (req.last_char) begin
                    trie_tag[row][ch]     = TAG_SYM;
                    trie_payload[row][ch] = (int'(req.symbol_id) >= SYMBOL_COUNT) ?
                                            PAYLOAD_W'(SYMBOL_COUNT - 1) :
                                            PAYLOAD_W'(req.symbol_id);
                    def_node   = 0;
                    res.status = ST_DEFINED;
                end else if (trie_tag[row][ch] == TAG_CHILD) begin
                    def_node   = int'(trie_payload[row][ch]);
                    def_node   = (def_node < NODE_COUNT) ? def_node : 0;
                    res.status = ST_PENDING;
                end else if (nodes_used >= NODE_COUNT) begin
                    def_dropped = 1'b1;
                    res.status  = ST_NO_NODES;
                end else begin
                    trie_tag[row][ch]     = TAG_CHILD;
                    trie_payload[row][ch] = PAYLOAD_W'(nodes_used);
                    def_node   = nodes_used;
                    nodes_used = nodes_used + 1;
                    res.status = ST_PENDING;
                end
            end
        end else if (walk_len >= MAX_KEY_LENGTH) begin
            walk_node  = 0;
            walk_len   = 0;
            res.status = ST_TOO_LONG;
        end else begin
            walk_len  = walk_len + 1;
            row       = (walk_node < NODE_COUNT) ? walk_node : 0;
            entry_tag = (ch < ALPHABET_SIZE) ? trie_tag[row][ch] : TAG_EMPTY;
            if (entry_tag == TAG_CHILD) begin
                walk_node  = int'(trie_payload[row][ch]);
                walk_node  = (walk_node < NODE_COUNT) ? walk_node : 0;
                res.status = ST_PENDING;
            end else if (entry_tag == TAG_SYM) begin
                res.status          = ST_MATCHED;
                res.matched_symbol  = trie_payload[row][ch][SYM_W-1:0];
                res.sequence_length = LEN_W'(walk_len);
                walk_node = 0;
                walk_len  = 0;
            end else begin
                walk_node  = 0;
                walk_len   = 0;
                res.status = ST_MISS;
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: called and returns at a falling edge
    // ------------------------------------------------------------------
    task automatic send_request(in_item_t req);
        int unsigned gap;
        gap = sender_gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(predict_key_result(req));
        if (req.cmd == CMD_DEFINE) defines_sent++;
        else matches_sent++;
        @(negedge aclk);
    endtask

    task automatic send_define(logic [7:0] ch, logic last, logic [SYM_W-1:0] sym);
        in_item_t req;
        req.cmd       = CMD_DEFINE;
        req.key_char  = ch;
        req.last_char = last;
        req.symbol_id = sym;
        send_request(req);
    endtask

    // unused fields of a match request carry random bits
    task automatic send_match(logic [7:0] ch);
        in_item_t req;
        req.cmd       = CMD_MATCH;
        req.key_char  = ch;
        req.last_char = 1'($urandom_range(0, 1));
        req.symbol_id = SYM_W'($urandom_range(0, 1023));
        send_request(req);
    endtask

    // Sender pause until every outstanding request has its result
    task automatic wait_results_done();
        s_valid <= 1'b0;
        do @(negedge aclk); while (expected_results.size() != 0);
    endtask

    // Define the key in key_buf and remember it for later walks
    task automatic define_key_buf(logic [SYM_W-1:0] sym);
        int unsigned slot;
        for (int i = 0; i < key_buf_len; i++) begin
            send_define(key_buf[i], i == key_buf_len - 1,
                        (i == key_buf_len - 1) ? sym : SYM_W'($urandom_range(0, 1023)));
        end
        slot = (stored_count < KEY_SLOTS) ? stored_count : $urandom_range(0, KEY_SLOTS - 1);
        if (stored_count < KEY_SLOTS) stored_count++;
        for (int i = 0; i < key_buf_len; i++) stored_key[slot][i] = key_buf[i];
        stored_len[slot] = key_buf_len;
    endtask

    function automatic logic [7:0] pick_char();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
                                             char_pool[$urandom_range(0, 7)];
    endfunction

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (int'(m_data.status) < 6) status_seen[m_data.status]++;
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("[%0t] unexpected result: status %0d symbol %0d length %0d",
                             $realtime, m_data.status, m_data.matched_symbol,
                             m_data.sequence_length);
            end else begin
                oldest_expected = expected_results.pop_front();
                if (m_data.status != oldest_expected.status ||
                    m_data.matched_symbol != oldest_expected.matched_symbol ||
                    m_data.sequence_length != oldest_expected.sequence_length) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("[%0t] mismatch: status %0d/%0d symbol %0d/%0d length %0d/%0d (exp/act)",
                                 $realtime,
                                 oldest_expected.status, m_data.status,
                                 oldest_expected.matched_symbol, m_data.matched_symbol,
                                 oldest_expected.sequence_length, m_data.sequence_length);
                end
            end
        end
    end

    // Result channel backpressure: a random stall before each result
    initial begin : result_sink
        int unsigned stall;
        forever begin
            @(negedge aclk);
            stall = receiver_gaps_on ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // Watchdog on handshake activity
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no handshake for %0d cycles, %0d results outstanding",
                     $realtime, quiet_cycles, expected_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Nothing defined yet: every character misses
    task automatic test_empty_trie();
        send_match(8'h00);
        send_match(8'hFF);
        wait_results_done();
    endtask

    // Two-character key and a one-character key at the extremes
    task automatic test_short_keys();
        send_define(8'h00, 1'b0, 10'h000);
        send_define(8'hFF, 1'b1, 10'h3FF);
        send_define(8'hFF, 1'b1, 10'h000);
        send_match(8'h00);
        send_match(8'hFF);
        send_match(8'hFF);
        wait_results_done();
    endtask

    // A miss mid-walk consumes the character; the walk restarts at the root
    task automatic test_miss_midway();
        send_match(8'h00);
        send_match(8'h41);
        send_match(8'hFF);
        wait_results_done();
    endtask

    // A non-last define over a symbol entry turns it into a link
    task automatic test_symbol_to_link();
        send_define(8'hFF, 1'b0, 10'h155);
        send_define(8'h01, 1'b1, 10'h2AA);
        send_match(8'hFF);
        send_match(8'h01);
        wait_results_done();
    endtask

    // A symbol cuts off a subtree while a walk is inside it
    task automatic test_subtree_overwrite();
        send_define(8'h10, 1'b0, 10'h000);
        send_define(8'h20, 1'b0, 10'h000);
        send_define(8'h30, 1'b1, 10'd5);
        send_match(8'h10);
        send_define(8'h10, 1'b1, 10'd7);
        send_match(8'h20);
        send_match(8'h30);
        send_match(8'h10);
        wait_results_done();
    endtask

    // 21-character key: the walk hits the length limit before the symbol
    task automatic test_long_key();
        key_buf[0] = 8'h7E;
        for (int i = 1; i < 21; i++) key_buf[i] = 8'($urandom_range(0, 255));
        key_buf_len = 21;
        define_key_buf(10'd513);
        for (int i = 0; i < 21; i++) send_match(key_buf[i]);
        wait_results_done();
    endtask

    // Random well-formed keys and walks with noise; nodes run out early, so
    // out-of-nodes and abandoned keys show up throughout the run
    task automatic test_random_traffic();
        int unsigned start_count;
        int unsigned choice;
        int unsigned slot;
        int unsigned extra;
        in_item_t    req;
        start_count = defines_sent + matches_sent;
        while (defines_sent + matches_sent - start_count < RANDOM_ITEMS) begin
            if ($urandom_range(0, 19) == 0) sender_gaps_on = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 19) == 0) receiver_gaps_on = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 39) == 0) wait_results_done();
            choice = $urandom_range(0, 99);
            if (choice < 40) begin
                // define: a fresh key or a variant of a known one
                if (stored_count > 0 && $urandom_range(0, 9) < 3) begin
                    slot        = $urandom_range(0, stored_count - 1);
                    key_buf_len = $urandom_range(1, stored_len[slot]);
                    for (int i = 0; i < key_buf_len; i++) key_buf[i] = stored_key[slot][i];
                    extra = $urandom_range(0, 2);
                    for (int i = 0; i < extra && key_buf_len < KEY_MAX; i++) begin
                        key_buf[key_buf_len] = pick_char();
                        key_buf_len++;
                    end
                end else begin
                    key_buf_len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 22) :
                                                                $urandom_range(1, 4);
                    for (int i = 0; i < key_buf_len; i++) key_buf[i] = pick_char();
                end
                define_key_buf(SYM_W'($urandom_range(0, 1023)));
            end else if (choice < 80 && stored_count > 0) begin
                // walk a known key, sometimes cut short or with one bad character
                slot        = $urandom_range(0, stored_count - 1);
                key_buf_len = ($urandom_range(0, 6) == 0) ?
                              $urandom_range(1, stored_len[slot]) : stored_len[slot];
                extra       = ($urandom_range(0, 9) == 0) ? $urandom_range(0, key_buf_len - 1)
                                                          : KEY_MAX;
                for (int i = 0; i < key_buf_len; i++)
                    send_match((i == extra) ? 8'($urandom_range(0, 255)) : stored_key[slot][i]);
            end else begin
                // noise
                req.cmd       = cmd_t'($urandom_range(0, 1));
                req.key_char  = 8'($urandom_range(0, 255));
                req.last_char = 1'($urandom_range(0, 1));
                req.symbol_id = SYM_W'($urandom_range(0, 1023));
                send_request(req);
            end
        end
        sender_gaps_on   = 1'b1;
        receiver_gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        clear_trie_model();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_empty_trie();
        test_short_keys();
        test_miss_midway();
        test_symbol_to_link();
        test_subtree_overwrite();
        test_long_key();
        test_random_traffic();

        wait_results_done();
        repeat (8) @(posedge aclk);
        if (expected_results.size() != 0) fail_count++;

        $display("Sent %0d requests (%0d define, %0d match), checked %0d results, %0d failures.",
                 defines_sent + matches_sent, defines_sent, matches_sent,
                 results_checked, fail_count);
        $display("Statuses: defined %0d, out of nodes %0d, pending %0d, miss %0d, matched %0d, too long %0d",
                 status_seen[0], status_seen[1], status_seen[2],
                 status_seen[3], status_seen[4], status_seen[5]);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
